FILE: rtl/bba_pkg.sv
// Shared constants, types and helper functions of the bitmap block allocator.
package bba_pkg;

   localparam int NUM_BLOCKS    = 1024;
   localparam int MAP_WORD_BITS = 32;
   localparam int MAP_WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WORD_AW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W         = $clog2(MAP_WORD_BITS);
   localparam int BLK_W         = $clog2(MAP_WORDS * MAP_WORD_BITS);
   localparam int PAD_BITS      = MAP_WORDS * MAP_WORD_BITS - NUM_BLOCKS;

   localparam int IDX_W       = 10;
   localparam int STATUS_W    = 2;
   localparam int CMD_W       = 1;
   localparam int REQ_TDATA_W = ((IDX_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((IDX_W + 7) / 8) * 8;

   localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);

   localparam logic [MAP_WORD_BITS-1:0] LAST_PAD_MASK =
      ~({MAP_WORD_BITS{1'b1}} >> PAD_BITS);

   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] bit_idx;
   } first_zero_type;

   function automatic first_zero_type first_zero(input logic [MAP_WORD_BITS-1:0] word);
      first_zero_type r;
      r.found   = 1'b0;
      r.bit_idx = '0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            r.found   = 1'b1;
            r.bit_idx = BIT_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [MAP_WORD_BITS-1:0] reset_word(input logic [WORD_AW-1:0] addr);
      return (addr == '0) ? MAP_WORD_BITS'(1) : '0;
   endfunction

endpackage

FILE: rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                      rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bitmap_block_allocator.sv
// Top level of the first-fit bitmap block allocator.
// Allocate: scan from word 0 to the first word with a free bit (full: all words), then write.
// Free: read, then write back; out of range: no map access. One request in flight at a time.
// Next request accepted the cycle after the result loads; the word-per-cycle scan sets the rate.
// Reset is synchronous, active high; per-word valid bits make the map read as all zero
// except block 0, with no clearing pass.
module bitmap_block_allocator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bba_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [9:0] block_index
   input  logic [bba_pkg::CMD_W-1:0]          req_tuser,  // [0] cmd
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bba_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // [9:0] granted_index
   output logic [bba_pkg::STATUS_W-1:0]       rsp_tuser   // [1:0] status
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_ALLOC_WR = 3'd2;
   localparam logic [2:0] S_FREE_RD  = 3'd3;
   localparam logic [2:0] S_FREE_WR  = 3'd4;
   localparam logic [2:0] S_DONE     = 3'd5;

   localparam int WB = bba_pkg::MAP_WORD_BITS;
   localparam int AW = bba_pkg::WORD_AW;

   logic [2:0]                    state_ff, state_in;
   logic [bba_pkg::MAP_WORDS-1:0] valid_ff, valid_in;
   logic [AW-1:0]                 scan_addr_ff, scan_addr_in;
   logic                          chk_ff, chk_in;
   logic [AW-1:0]                 chk_addr_ff, chk_addr_in;
   logic [AW-1:0]                 op_addr_ff, op_addr_in;
   logic [bba_pkg::BIT_W-1:0]     op_bit_ff, op_bit_in;
   logic [WB-1:0]                 alloc_word_ff, alloc_word_in;
   logic [WB-1:0]                 alloc_mask_ff, alloc_mask_in;
   logic [bba_pkg::IDX_W-1:0]     res_idx_ff, res_idx_in;
   logic [bba_pkg::STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [bba_pkg::IDX_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic [bba_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic [bba_pkg::IDX_W-1:0]     req_idx;
   logic [bba_pkg::CMD_W-1:0]     req_cmd;
   logic                          req_fire;
   logic                          req_in_range;

   logic                          ram_we;
   logic [AW-1:0]                 ram_wr_addr;
   logic [WB-1:0]                 ram_wr_data;
   logic [AW-1:0]                 ram_rd_addr;
   logic [WB-1:0]                 ram_rd_data;

   logic [AW-1:0]                 eff_addr;
   logic [WB-1:0]                 eff_word;
   logic [WB-1:0]                 scan_word;
   bba_pkg::first_zero_type       fz;
   logic [bba_pkg::BLK_W-1:0]     grant_blk;

   assign req_idx      = req_tdata[bba_pkg::IDX_W-1:0];
   assign req_cmd      = req_tuser;
   assign req_tready   = (state_ff == S_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign req_in_range = 32'(req_idx) < 32'(bba_pkg::NUM_BLOCKS);

   assign ram_rd_addr = (state_ff == S_SCAN) ? scan_addr_ff : op_addr_ff;
   assign eff_addr    = (state_ff == S_SCAN) ? chk_addr_ff : op_addr_ff;
   assign eff_word    = valid_ff[eff_addr] ? ram_rd_data : bba_pkg::reset_word(eff_addr);
   assign scan_word   = (chk_addr_ff == bba_pkg::LAST_WORD) ?
                        (eff_word | bba_pkg::LAST_PAD_MASK) : eff_word;
   assign fz          = bba_pkg::first_zero(scan_word);
   assign grant_blk   = bba_pkg::BLK_W'(chk_addr_ff) * bba_pkg::BLK_W'(WB)
                        + bba_pkg::BLK_W'(fz.bit_idx);

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      scan_addr_in  = scan_addr_ff;
      chk_in        = chk_ff;
      chk_addr_in   = chk_addr_ff;
      op_addr_in    = op_addr_ff;
      op_bit_in     = op_bit_ff;
      alloc_word_in = alloc_word_ff;
      alloc_mask_in = alloc_mask_ff;
      res_idx_in    = res_idx_ff;
      res_status_in = res_status_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_idx_in    = rsp_idx_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = op_addr_ff;
      ram_wr_data   = alloc_word_ff | alloc_mask_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_cmd == bba_pkg::CMD_ALLOC) begin
                  scan_addr_in = '0;
                  chk_in       = 1'b0;
                  state_in     = S_SCAN;
               end else if (req_in_range) begin
                  op_addr_in = AW'(req_idx / bba_pkg::MAP_WORD_BITS);
                  op_bit_in  = bba_pkg::BIT_W'(req_idx % bba_pkg::MAP_WORD_BITS);
                  state_in   = S_FREE_RD;
               end else begin
                  res_idx_in    = '0;
                  res_status_in = bba_pkg::STATUS_RANGE;
                  state_in      = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (chk_ff && fz.found) begin
               alloc_word_in = eff_word;
               alloc_mask_in = {{(WB-1){1'b0}}, 1'b1} << fz.bit_idx;
               op_addr_in    = chk_addr_ff;
               res_idx_in    = bba_pkg::IDX_W'(grant_blk);
               res_status_in = bba_pkg::STATUS_OK;
               state_in      = S_ALLOC_WR;
            end else if (chk_ff && (chk_addr_ff == bba_pkg::LAST_WORD)) begin
               res_idx_in    = '0;
               res_status_in = bba_pkg::STATUS_FULL;
               state_in      = S_DONE;
            end else begin
               chk_in      = 1'b1;
               chk_addr_in = scan_addr_ff;
               if (scan_addr_ff != bba_pkg::LAST_WORD) begin
                  scan_addr_in = scan_addr_ff + AW'(1);
               end
            end
         end
         S_ALLOC_WR: begin
            ram_we               = 1'b1;
            valid_in[op_addr_ff] = 1'b1;
            state_in             = S_DONE;
         end
         S_FREE_RD: begin
            state_in = S_FREE_WR;
         end
         S_FREE_WR: begin
            ram_we               = 1'b1;
            ram_wr_data          = eff_word & ~({{(WB-1){1'b0}}, 1'b1} << op_bit_ff);
            valid_in[op_addr_ff] = 1'b1;
            res_idx_in           = '0;
            res_status_in        = bba_pkg::STATUS_OK;
            state_in             = S_DONE;
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_idx_in    = res_idx_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         chk_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         chk_ff        <= chk_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      scan_addr_ff  <= scan_addr_in;
      chk_addr_ff   <= chk_addr_in;
      op_addr_ff    <= op_addr_in;
      op_bit_ff     <= op_bit_in;
      alloc_word_ff <= alloc_word_in;
      alloc_mask_ff <= alloc_mask_in;
      res_idx_ff    <= res_idx_in;
      res_status_ff <= res_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_status_ff <= rsp_status_in;
   end

   bba_ram #(
      .DATA_W (WB),
      .DEPTH  (bba_pkg::MAP_WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = bba_pkg::RSP_TDATA_W'(rsp_idx_ff);
   assign rsp_tuser  = rsp_status_ff;

   a_alloc_sets_free_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC_WR) |->
         ($onehot(alloc_mask_ff) && ((alloc_word_ff & alloc_mask_ff) == '0)))
      else $error("allocation marks a bit that is not a single free bit");

   a_fail_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != bba_pkg::STATUS_OK)) |->
         (rsp_tdata[bba_pkg::IDX_W-1:0] == '0))
      else $error("failed request carries a nonzero index");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == bba_pkg::STATUS_OK || rsp_tuser == bba_pkg::STATUS_FULL
                      || rsp_tuser == bba_pkg::STATUS_RANGE))
      else $error("undefined status code");

   a_write_only_in_update: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_ALLOC_WR || state_ff == S_FREE_WR))
      else $error("map write outside an update step");

   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && chk_ff) |-> (chk_addr_ff <= scan_addr_ff))
      else $error("scan check runs ahead of the read address");

endmodule

FILE: verif/bitmap_block_allocator_checker.sv
// Monitor, usage-map predictor and response comparator for the bitmap block allocator.
`timescale 1ns / 1ps

module bitmap_block_allocator_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [bba_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [bba_pkg::CMD_W-1:0]       req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [bba_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [bba_pkg::STATUS_W-1:0]    rsp_tuser,
   output int                              answers_pending,
   output int                              mismatch_count
);

   typedef struct {
      logic [bba_pkg::IDX_W-1:0]    granted_index;
      logic [bba_pkg::STATUS_W-1:0] status;
   } grant_answer_type;

   logic [bba_pkg::NUM_BLOCKS-1:0] block_used = bba_pkg::NUM_BLOCKS'(1);
   grant_answer_type               answers_due[$];
   int                             pending_total  = 0;
   int                             mismatch_total = 0;

   assign answers_pending = pending_total;
   assign mismatch_count  = mismatch_total;

   function automatic grant_answer_type serve_request(input logic [bba_pkg::CMD_W-1:0] cmd,
                                                      input logic [bba_pkg::IDX_W-1:0] idx);
      grant_answer_type ans;
      ans.granted_index = '0;
      ans.status        = bba_pkg::STATUS_OK;
      if (cmd == bba_pkg::CMD_ALLOC) begin
         ans.status = bba_pkg::STATUS_FULL;
         for (int blk = 0; blk < bba_pkg::NUM_BLOCKS; blk++) begin
            if (!block_used[blk]) begin
               block_used[blk]   = 1'b1;
               ans.granted_index = bba_pkg::IDX_W'(blk);
               ans.status        = bba_pkg::STATUS_OK;
               break;
            end
         end
      end else if (int'(idx) >= bba_pkg::NUM_BLOCKS) begin
         ans.status = bba_pkg::STATUS_RANGE;
      end else begin
         block_used[idx] = 1'b0;
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      grant_answer_type due;
      if (reset) begin
         block_used = bba_pkg::NUM_BLOCKS'(1);
         answers_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected transfer, granted_index %0d status %0d",
                        $time, rsp_tdata, rsp_tuser);
               mismatch_total++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_tdata !== bba_pkg::RSP_TDATA_W'(due.granted_index)) begin
                  $display("%0t: granted_index expected %0d actual %0d",
                           $time, due.granted_index, rsp_tdata);
                  mismatch_total++;
               end
               if (rsp_tuser !== due.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, due.status, rsp_tuser);
                  mismatch_total++;
               end
            end
         end
         if (req_tvalid && req_tready)
            answers_due.push_back(serve_request(req_tuser,
                                                req_tdata[bba_pkg::IDX_W-1:0]));
      end
      pending_total <= answers_due.size();
   end

endmodule

FILE: verif/bitmap_block_allocator_tb.sv
// Testbench top: clock, reset, request stimulus, response back-pressure and verdict.
`timescale 1ns / 1ps

module bitmap_block_allocator_tb;

   localparam int CYCLE_LIMIT = 400000;

   typedef enum {READY_ALWAYS, READY_COIN, READY_EVERY_FOURTH, READY_SPARSE} ready_mode_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [bba_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [bba_pkg::CMD_W-1:0]       req_tuser  = bba_pkg::CMD_ALLOC;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [bba_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [bba_pkg::STATUS_W-1:0]    rsp_tuser;

   int             answers_pending;
   int             mismatch_count;
   int             burst_left  = 0;
   int             allocs_sent = 0;
   int unsigned    cycle_count = 0;
   int unsigned    stall_tick  = 0;
   ready_mode_type stall_mode  = READY_ALWAYS;

   bitmap_block_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   bitmap_block_allocator_checker answer_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .answers_pending (answers_pending),
      .mismatch_count  (mismatch_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("bitmap_block_allocator regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 200 == 0)
         stall_mode <= ready_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         READY_ALWAYS:       rsp_tready <= 1'b1;
         READY_COIN:         rsp_tready <= 1'($urandom_range(0, 1));
         READY_EVERY_FOURTH: rsp_tready <= (stall_tick % 4 == 0);
         default:            rsp_tready <= ($urandom_range(0, 11) == 0);
      endcase
   end

   task automatic push_request(input logic [bba_pkg::CMD_W-1:0] cmd,
                               input logic [bba_pkg::IDX_W-1:0] idx);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= bba_pkg::REQ_TDATA_W'(idx);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      if (cmd == bba_pkg::CMD_ALLOC)
         allocs_sent++;
   endtask

   // favor blocks that have likely been handed out
   function automatic logic [bba_pkg::IDX_W-1:0] pick_free_index();
      int top_blk;
      top_blk = (allocs_sent + 4 > bba_pkg::NUM_BLOCKS - 1) ? bba_pkg::NUM_BLOCKS - 1
                                                            : allocs_sent + 4;
      if ($urandom_range(0, 9) < 7)
         return bba_pkg::IDX_W'($urandom_range(0, top_blk));
      return bba_pkg::IDX_W'($urandom_range(0, 1023));
   endfunction

   task automatic random_mix(input int count, input int alloc_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < alloc_pct)
            push_request(bba_pkg::CMD_ALLOC, bba_pkg::IDX_W'($urandom_range(0, 1023)));
         else
            push_request(bba_pkg::CMD_FREE, pick_free_index());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_request(bba_pkg::CMD_ALLOC, 10'h3FF);
      push_request(bba_pkg::CMD_ALLOC, 10'h000);
      push_request(bba_pkg::CMD_FREE,  10'd1);
      push_request(bba_pkg::CMD_ALLOC, 10'h2AA);
      push_request(bba_pkg::CMD_FREE,  10'd0);
      push_request(bba_pkg::CMD_ALLOC, 10'h155);
      push_request(bba_pkg::CMD_FREE,  10'h3FF);
      push_request(bba_pkg::CMD_FREE,  10'h3FF);
      push_request(bba_pkg::CMD_FREE,  10'h155);
      push_request(bba_pkg::CMD_FREE,  10'h2AA);
      push_request(bba_pkg::CMD_FREE,  10'd0);
      push_request(bba_pkg::CMD_FREE,  10'd0);
      push_request(bba_pkg::CMD_ALLOC, 10'h000);
      push_request(bba_pkg::CMD_ALLOC, 10'h3FF);
      push_request(bba_pkg::CMD_FREE,  10'd2);
      push_request(bba_pkg::CMD_ALLOC, 10'h000);
      push_request(bba_pkg::CMD_FREE,  10'h200);

      random_mix(380, 65);

      push_request(bba_pkg::CMD_FREE,  10'h3FF);
      push_request(bba_pkg::CMD_ALLOC, 10'h000);
      push_request(bba_pkg::CMD_ALLOC, 10'h000);
      push_request(bba_pkg::CMD_FREE,  10'd0);
      push_request(bba_pkg::CMD_ALLOC, 10'h3FF);
      push_request(bba_pkg::CMD_FREE,  10'h1F0);
      push_request(bba_pkg::CMD_ALLOC, 10'h000);
      push_request(bba_pkg::CMD_ALLOC, 10'h000);

      for (int i = 0; i < 150; i++) begin
         if ($urandom_range(0, 1) == 0)
            push_request(bba_pkg::CMD_ALLOC, bba_pkg::IDX_W'($urandom_range(0, 1023)));
         else
            push_request(bba_pkg::CMD_FREE, bba_pkg::IDX_W'($urandom_range(0, 1023)));
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (answers_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("bitmap_block_allocator regression: pass");
      else
         $display("bitmap_block_allocator regression: fail");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bitmap_block_allocator.sv
verif/bitmap_block_allocator_checker.sv
verif/bitmap_block_allocator_tb.sv
